@@ design/dsst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dual-sensor sun tracker core.
// No dependencies; imported by the core, its port checker and the test bench.
package dsst_pkg;

    localparam int SENSOR_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int PCT_BITS    = 7;
    localparam int CFG_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;

    // input word: light_a, light_b, end_a_clear, end_b_clear, time_ms
    localparam int IN_FIELD_BITS = 2 * SENSOR_BITS + 2 + TIME_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    // output word: drive_cw, drive_ccw, motion_status, tracking_active
    localparam int STATUS_BITS    = 3;
    localparam int OUT_FIELD_BITS = 2 + STATUS_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int PCT_SCALE = 100;
    localparam int PROD_BITS = SENSOR_BITS + PCT_BITS + 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DARK_THRESHOLD  = 2'd0,
        REG_BALANCE_PERCENT = 2'd1,
        REG_REST_PERIOD_MS  = 2'd2,
        REG_UNUSED          = 2'd3
    } cfg_index_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_STOP  = 3'd0,
        ST_CW    = 3'd1,
        ST_CCW   = 3'd2,
        ST_END_A = 3'd3,
        ST_END_B = 3'd4
    } status_t;

    localparam logic [SENSOR_BITS-1:0] DARK_RESET    = '0;
    localparam logic [PCT_BITS-1:0]    BALANCE_RESET = 7'd10;
    localparam logic [PCT_BITS-1:0]    BALANCE_MAX   = 7'd100;
    localparam logic [TIME_BITS-1:0]   REST_RESET    = 32'd60000;

endpackage

@@ design/dual_sensor_sun_tracker_core.sv @@
`timescale 1ns / 1ps
// Dual-sensor sun tracker core: input register, one pass of compare logic,
// tracker state registers that double as the result word. Uses dsst_pkg.
//
//  channel | dir | tdata fields, lowest bit first
//  s_axis  | in  | light_a[11:0] light_b[23:12] end_a_clear[24] end_b_clear[25]
//          |     | time_ms[57:26], zero pad to 64
//  m_axis  | out | drive_cw[0] drive_ccw[1] motion_status[4:2] tracking_active[5]
//  cfg     | in  | cfg_wr_en, cfg_index, cfg_wdata; written on any enabled edge
//
// One word per cycle sustained while the output is not stalled; each word passes
// through the input register, then the state/result register, before its
// result word can be taken.
// The tracker state registers are the result register, so a stalled output
// holds the state; the input register can still take one word meanwhile.
// Reset clears the state and loads the register defaults; no clearing pass.
module dual_sensor_sun_tracker_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // light_a, light_b, end_a_clear, end_b_clear, time_ms, zero pad
    input  logic [dsst_pkg::IN_DATA_BITS-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // drive_cw, drive_ccw, motion_status, tracking_active, zero pad
    output logic [dsst_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [dsst_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [dsst_pkg::CFG_BITS-1:0]     cfg_wdata
);
    import dsst_pkg::*;

    localparam int A_LO = 0;
    localparam int B_LO = SENSOR_BITS;
    localparam int EA_BIT = 2 * SENSOR_BITS;
    localparam int EB_BIT = EA_BIT + 1;
    localparam int T_LO = EB_BIT + 1;

    // configuration
    logic [SENSOR_BITS-1:0] dark_reg;
    logic [PCT_BITS-1:0]    balance_reg;
    logic [TIME_BITS-1:0]   rest_reg;

    // input register
    logic                   in_valid_reg;
    logic [SENSOR_BITS-1:0] light_a_reg;
    logic [SENSOR_BITS-1:0] light_b_reg;
    logic                   end_a_reg;
    logic                   end_b_reg;
    logic [TIME_BITS-1:0]   time_reg;

    // tracker state / result
    logic                   out_valid_reg;
    logic                   tracking_reg, tracking_next;
    logic [TIME_BITS-1:0]   last_stop_reg, last_stop_next;
    logic                   cw_reg, cw_next;
    logic                   ccw_reg, ccw_next;
    status_t                status_reg, status_next;

    logic                   advance;
    logic                   in_take;
    logic [SENSOR_BITS:0]   sum;
    logic [SENSOR_BITS-1:0] avg;
    logic [SENSOR_BITS-1:0] diff;
    logic [PROD_BITS-1:0]   allowed_x100;
    logic [PROD_BITS-1:0]   diff_x100;
    logic                   balanced;
    logic                   too_dark;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   run;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg    <= DARK_RESET;
            balance_reg <= BALANCE_RESET;
            rest_reg    <= REST_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DARK_THRESHOLD:
                    dark_reg <= cfg_wdata[SENSOR_BITS-1:0];
                REG_BALANCE_PERCENT:
                    if (cfg_wdata[PCT_BITS-1:0] <= BALANCE_MAX)
                        balance_reg <= cfg_wdata[PCT_BITS-1:0];
                REG_REST_PERIOD_MS:
                    if (cfg_wdata[TIME_BITS-1:0] != '0)
                        rest_reg <= cfg_wdata[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            light_a_reg <= s_tdata[A_LO +: SENSOR_BITS];
            light_b_reg <= s_tdata[B_LO +: SENSOR_BITS];
            end_a_reg   <= s_tdata[EA_BIT];
            end_b_reg   <= s_tdata[EB_BIT];
            time_reg    <= s_tdata[T_LO +: TIME_BITS];
        end
    end

    // diff < floor(avg * pct / 100)  <=>  100 * (diff + 1) <= avg * pct
    always_comb
    begin
        sum  = {1'b0, light_a_reg} + {1'b0, light_b_reg};
        avg  = sum[SENSOR_BITS:1];
        diff = (light_a_reg > light_b_reg) ? (light_a_reg - light_b_reg)
                                           : (light_b_reg - light_a_reg);
        allowed_x100 = PROD_BITS'(avg) * PROD_BITS'(balance_reg);
        diff_x100    = PROD_BITS'(diff) * PROD_BITS'(PCT_SCALE)
                     + PROD_BITS'(PCT_SCALE);
        balanced = diff_x100 <= allowed_x100;
        too_dark = (light_a_reg < dark_reg) && (light_b_reg < dark_reg);
        elapsed  = time_reg - last_stop_reg;
        run      = tracking_reg || (elapsed > rest_reg);

        tracking_next  = run;
        last_stop_next = last_stop_reg;
        cw_next        = cw_reg;
        ccw_next       = ccw_reg;
        status_next    = status_reg;
        if (run)
        begin
            if (balanced || too_dark)
            begin
                tracking_next  = 1'b0;
                cw_next        = 1'b0;
                ccw_next       = 1'b0;
                status_next    = ST_STOP;
                last_stop_next = time_reg;
            end
            else if ((light_a_reg > light_b_reg) && end_a_reg)
            begin
                cw_next     = 1'b1;
                ccw_next    = 1'b0;
                status_next = ST_CW;
            end
            else if ((light_a_reg < light_b_reg) && end_b_reg)
            begin
                cw_next     = 1'b0;
                ccw_next    = 1'b1;
                status_next = ST_CCW;
            end
            // end B wins when both switches are pressed
            if (!end_a_reg)
                status_next = ST_END_A;
            if (!end_b_reg)
                status_next = ST_END_B;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tracking_reg  <= 1'b0;
            last_stop_reg <= '0;
            cw_reg        <= 1'b0;
            ccw_reg       <= 1'b0;
            status_reg    <= ST_STOP;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                tracking_reg  <= tracking_next;
                last_stop_reg <= last_stop_next;
                cw_reg        <= cw_next;
                ccw_reg       <= ccw_next;
                status_reg    <= status_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'({tracking_reg, status_reg, ccw_reg, cw_reg});

endmodule

@@ design/dsst_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the sun tracker core, bound to the top level.
// Uses dsst_pkg for widths and status codes.
module dsst_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [dsst_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import dsst_pkg::*;

    logic    drv_cw;
    logic    drv_ccw;
    status_t status;
    logic    active;

    assign drv_cw  = m_tdata[0];
    assign drv_ccw = m_tdata[1];
    assign status  = status_t'(m_tdata[4:2]);
    assign active  = m_tdata[5];

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(drv_cw && drv_ccw))
        else $error("both relays driven");

    // idle means the last event was a stop or reset, both clear the relays
    a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !active |-> !drv_cw && !drv_ccw)
        else $error("relay driven while not tracking");

    a_status_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == ST_CW) |-> drv_cw)
        else $error("cw status without cw drive");

endmodule

bind dual_sensor_sun_tracker_core dsst_checker u_dsst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/dual_sensor_sun_tracker_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dual_sensor_sun_tracker_core: a predictor of the tracker
// checks every output word. Uses dsst_pkg and the core RTL, nothing else.
module dual_sensor_sun_tracker_core_test;
    import dsst_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int REPORT_MAX  = 10;

    // packed so that the last field declared, light_a, lands in the lowest bits
    typedef struct packed {
        logic [TIME_BITS-1:0]   time_ms;
        logic                   end_b_clear;
        logic                   end_a_clear;
        logic [SENSOR_BITS-1:0] light_b;
        logic [SENSOR_BITS-1:0] light_a;
    } sample_t;

    typedef struct packed {
        logic    tracking_active;
        status_t motion_status;
        logic    drive_ccw;
        logic    drive_cw;
    } move_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    dual_sensor_sun_tracker_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    // predictor copy of the registers and tracker state
    logic [SENSOR_BITS-1:0] dark_lvl = DARK_RESET;
    logic [PCT_BITS-1:0]    balance_pct = BALANCE_RESET;
    logic [TIME_BITS-1:0]   rest_ms = REST_RESET;
    logic                   tracking = 1'b0;
    logic [TIME_BITS-1:0]   last_stop_ms = '0;
    logic                   cw_q = 1'b0;
    logic                   ccw_q = 1'b0;
    status_t                status_q = ST_STOP;

    move_t expected_moves[$];
    int err_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    logic [TIME_BITS-1:0] now_ms = '0;
    int time_step_max = 10;

    function automatic void apply_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] val);
        case (idx)
            REG_DARK_THRESHOLD: dark_lvl = val[SENSOR_BITS-1:0];
            REG_BALANCE_PERCENT:
                if (val[PCT_BITS-1:0] <= BALANCE_MAX)
                    balance_pct = val[PCT_BITS-1:0];
            REG_REST_PERIOD_MS:
                if (val != '0)
                    rest_ms = val;
            default: ;
        endcase
    endfunction

    function automatic move_t track_sample(input sample_t smp);
        logic [SENSOR_BITS:0]   sum;
        logic [SENSOR_BITS-1:0] avg;
        logic [SENSOR_BITS-1:0] diff;
        logic [31:0]            allowed;
        logic [TIME_BITS-1:0]   elapsed;
        move_t                  mv;
        sum = {1'b0, smp.light_a} + {1'b0, smp.light_b};
        avg = sum[SENSOR_BITS:1];
        allowed = (32'(avg) * 32'(balance_pct)) / 32'(PCT_SCALE);
        diff = (smp.light_a > smp.light_b) ? smp.light_a - smp.light_b
                                           : smp.light_b - smp.light_a;
        elapsed = smp.time_ms - last_stop_ms;
        if (!tracking && elapsed > rest_ms)
            tracking = 1'b1;
        if (tracking)
        begin
            if (32'(diff) < allowed || (smp.light_a < dark_lvl && smp.light_b < dark_lvl))
            begin
                tracking = 1'b0;
                cw_q = 1'b0;
                ccw_q = 1'b0;
                status_q = ST_STOP;
                last_stop_ms = smp.time_ms;
            end
            else if (smp.light_a > smp.light_b && smp.end_a_clear)
            begin
                cw_q = 1'b1;
                ccw_q = 1'b0;
                status_q = ST_CW;
            end
            else if (smp.light_a < smp.light_b && smp.end_b_clear)
            begin
                cw_q = 1'b0;
                ccw_q = 1'b1;
                status_q = ST_CCW;
            end
            // end switches only flag the status, relays keep their level
            if (!smp.end_a_clear)
                status_q = ST_END_A;
            if (!smp.end_b_clear)
                status_q = ST_END_B;
        end
        mv.drive_cw = cw_q;
        mv.drive_ccw = ccw_q;
        mv.motion_status = status_q;
        mv.tracking_active = tracking;
        return mv;
    endfunction

    function automatic sample_t mk(input int a, input int b, input logic ea, input logic eb,
                                   input logic [TIME_BITS-1:0] t);
        sample_t smp;
        smp.light_a = a[SENSOR_BITS-1:0];
        smp.light_b = b[SENSOR_BITS-1:0];
        smp.end_a_clear = ea;
        smp.end_b_clear = eb;
        smp.time_ms = t;
        return smp;
    endfunction

    function automatic int clamp_reading(input int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    function automatic sample_t random_sample();
        int a;
        int b;
        int d;
        int mode;
        int tsel;
        mode = $urandom_range(0, 9);
        if (mode < 3)
        begin
            a = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
        end
        else if (mode < 6)
        begin
            // near balance, around the stop threshold
            a = $urandom_range(0, 4095);
            d = $urandom_range(0, a / 5 + 3);
            b = clamp_reading($urandom_range(0, 1) ? a + d : a - d);
        end
        else if (mode < 8)
        begin
            a = clamp_reading($urandom_range(0, int'(dark_lvl) + 40));
            b = clamp_reading($urandom_range(0, int'(dark_lvl) + 40));
        end
        else
        begin
            a = $urandom_range(0, 1) ? 4095 - $urandom_range(0, 20) : $urandom_range(0, 20);
            b = $urandom_range(0, 1) ? 4095 - $urandom_range(0, 20) : $urandom_range(0, 20);
        end
        tsel = $urandom_range(0, 31);
        if (tsel == 0)
            now_ms = $urandom();
        else if (tsel == 1)
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else
            now_ms = now_ms + $urandom_range(0, time_step_max);
        return mk(a, b, $urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0, now_ms);
    endfunction

    // called at a rising edge; leaves tvalid high so back-to-back words need no toggle
    task automatic send_sample(input sample_t smp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_BITS - IN_FIELD_BITS){1'b0}}, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_moves.push_back(track_sample(smp));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int idle, input int stall,
                                input logic [CFG_BITS-1:0] dark, input logic [CFG_BITS-1:0] bal,
                                input logic [CFG_BITS-1:0] rest, input int step);
        wait_drained();
        write_reg(REG_DARK_THRESHOLD, dark);
        write_reg(REG_BALANCE_PERCENT, bal);
        write_reg(REG_REST_PERIOD_MS, rest);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        time_step_max = step;
        repeat (n) send_sample(random_sample());
    endtask

    // defaults after reset: 60 s rest, 10 percent balance, no dark limit
    task automatic test_reset_state();
        logic [TIME_BITS-1:0] t;
        send_sample(mk(0, 0, 1, 1, 32'd0));
        send_sample(mk(4095, 0, 1, 1, 32'd60000));      // elapsed equal to period: still idle
        send_sample(mk(4095, 0, 1, 1, 32'd60001));      // starts, cw
        send_sample(mk(0, 4095, 1, 1, 32'd60002));      // ccw
        send_sample(mk(5, 5, 1, 1, 32'd60003));         // equal, no stop: hold
        send_sample(mk(3000, 100, 0, 1, 32'd60004));    // end A hit, relays hold
        send_sample(mk(100, 3000, 0, 0, 32'd60005));    // both pressed: end B wins
        send_sample(mk(2000, 2000, 1, 1, 32'd60006));   // balanced stop
        t = 32'd60006 + 32'd60001;
        send_sample(mk(2000, 2010, 0, 1, t));           // restart and stop with end A pressed
        send_sample(mk(4095, 0, 0, 0, t + 32'd1));      // idle: status untouched
        // stop just before the wrap, then restart across it
        send_sample(mk(1000, 1000, 1, 1, 32'hFFFF_FF00));
        send_sample(mk(4000, 0, 1, 1, 32'hFFFF_FF00 + 32'd60000));
        send_sample(mk(4000, 0, 1, 1, 32'hFFFF_FF00 + 32'd60001));
        send_sample(mk(4095, 4095, 0, 1, 32'hFFFF_FF00 + 32'd60002));
    endtask

    task automatic test_registers();
        logic [TIME_BITS-1:0] t;
        wait_drained();
        write_reg(REG_BALANCE_PERCENT, 32'd101);        // out of range: ignored
        write_reg(REG_BALANCE_PERCENT, 32'd127);
        write_reg(REG_REST_PERIOD_MS, 32'd0);           // zero period: ignored
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(mk(1000, 1050, 1, 1, 32'h0100_0000));
        wait_drained();
        write_reg(REG_DARK_THRESHOLD, 32'd4095);
        write_reg(REG_BALANCE_PERCENT, 32'd0);
        write_reg(REG_REST_PERIOD_MS, 32'd1);
        t = 32'h0200_0000;
        send_sample(mk(4094, 4094, 1, 1, t));           // too dark: stop
        send_sample(mk(4095, 4094, 1, 1, t + 32'd1));   // elapsed 1, not over period
        send_sample(mk(4095, 4094, 1, 1, t + 32'd2));   // cw, diff 1 beats zero balance
        send_sample(mk(4095, 4095, 1, 1, t + 32'd3));   // equal, hold
        wait_drained();
        write_reg(REG_DARK_THRESHOLD, 32'hFFFF_F000);   // upper bits dropped
        write_reg(REG_BALANCE_PERCENT, 32'd100);
        write_reg(REG_REST_PERIOD_MS, 32'hFFFF_FFFF);
        send_sample(mk(1000, 1999, 1, 1, t + 32'd4));   // within full-average balance: stop
        send_sample(mk(0, 4095, 1, 1, t + 32'h8000_0000));
        send_sample(mk(4095, 0, 0, 0, t - 32'd1));      // max period never expires
    endtask

    task automatic test_random_mix();
        random_phase(450, 0, 0, 32'd100, 32'd10, 32'd5, 12);
        random_phase(300, 84, 0, 32'd0, 32'd100, 32'd1, 4);
        random_phase(300, 0, 84, 32'd2048, 32'd0, 32'd20, 60);
        random_phase(400, 38, 38, 32'd500, 32'd50, 32'd3, 8);
        random_phase(120, 0, 0, 32'd4095, 32'd100, 32'hFFFF_FFFF, 1000);
    endtask

    // receiver holds off while words keep coming, so the input side must stall
    task automatic test_backpressure();
        random_phase(0, 0, 0, 32'd300, 32'd15, 32'd2, 6);
        hold_req <= 300;
        repeat (40) send_sample(random_sample());
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_stall_pct = 20;
        repeat (20) send_sample(random_sample());
        wait_drained();
        repeat (20) send_sample(random_sample());
    endtask

    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req <= 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // output checker and stall watchdog
    always @(posedge clk)
    begin
        move_t got;
        move_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = move_t'(m_tdata[OUT_FIELD_BITS-1:0]);
                if (expected_moves.size() == 0)
                begin
                    err_count = err_count + 1;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected word: cw %0b ccw %0b status %0d tracking %0b",
                                 got.drive_cw, got.drive_ccw, got.motion_status,
                                 got.tracking_active);
                end
                else
                begin
                    want = expected_moves.pop_front();
                    if (got.drive_cw !== want.drive_cw || got.drive_ccw !== want.drive_ccw ||
                        got.motion_status !== want.motion_status ||
                        got.tracking_active !== want.tracking_active)
                    begin
                        err_count = err_count + 1;
                        if (err_count <= REPORT_MAX)
                            $display("mismatch: exp cw %0b ccw %0b status %0d tracking %0b, got cw %0b ccw %0b status %0d tracking %0b",
                                     want.drive_cw, want.drive_ccw, want.motion_status,
                                     want.tracking_active, got.drive_cw, got.drive_ccw,
                                     got.motion_status, got.tracking_active);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_registers();
        test_random_mix();
        test_backpressure();
        test_drain_pause();
        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0 && expected_moves.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
